[rtl/first_fit_heap_allocator_unit_assert.svh]
// Assertion macros used by the heap allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FFHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FFHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FFHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/ffha_pkg.sv]
// Package with types, codes and constants of the heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
  localparam int unsigned HEAP_BYTES_DEF   = 65536;
  localparam int unsigned BLOCK_BYTES_DEF  = 64;
  localparam int unsigned HEADER_BYTES_DEF = 32;
  localparam int unsigned MAX_SEGMENTS_DEF = 64;

  localparam int unsigned SZW = 17;   // byte offsets and sizes up to 65536
  localparam int unsigned ADW = 16;   // usable address width

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // One segment table entry.
  typedef struct packed {
    logic [SZW-1:0] start;
    logic [SZW-1:0] size;
    logic           used;
    logic [3:0]     tag;
  } seg_t;
endpackage
`default_nettype wire

[rtl/first_fit_heap_allocator_unit.sv]
// Top level of the first-fit heap allocator with its segment sequencer.
// The segment table is a memory of MAX_SEGMENTS entries kept in address order,
// with one registered read port and one write port. A fill count bounds it, and
// entry 0 is written with the whole heap while reset is held, so no clearing
// pass is needed. A transaction that needs no table access (unused selector,
// zero-size allocate, free of the null address) goes straight from acceptance
// to the done state. Any other transaction searches the table one entry at a
// time, up to the first hit. An allocation that splits then moves every entry
// above the hit up one place, and a free that merges moves the entries above
// it down one or two places, with one read and one write per moved entry. The
// searched and moved entries together never exceed the fill count. in_tready
// is high only while the sequencer is idle and the result register is empty
// or being taken. Requests are rounded up by shifting, so BLOCK_BYTES must be
// a power of two.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_heap_allocator_unit_assert.svh"
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int unsigned BLOCK_BYTES  = BLOCK_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // func[1:0], request_bytes[18:2], address[34:19], purpose[38:35], zeros
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_address[15:0], status[16], purpose_match[17], zeros
  output logic [23:0]      out_tdata
);
  localparam int unsigned IW  = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned BSH = $clog2(BLOCK_BYTES);
  localparam int unsigned NW  = SZW + 1;   // rounded request, up to 131072
  localparam int unsigned AW  = SZW + 2;   // shared unit, top bit is the borrow

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_UP_RD, S_UP_WR, S_SPLIT_WR, S_WR_HIT,
    S_NXT_RD, S_NXT, S_PRV_RD, S_PRV, S_MERGE, S_DN_RD, S_DN_WR, S_DONE
  } state_t;

  state_t          state_r;
  seg_t            mem [MAX_SEGMENTS];
  seg_t            rd_q;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  seg_t            wr_data;

  logic [CW-1:0]   count_r;
  logic [CW-1:0]   idx_r;      // walking index
  logic [CW-1:0]   hit_r;      // entry written back at the end
  seg_t            cur_r;      // new contents of that entry
  logic [CW-1:0]   drop_r;     // first entry removed by a merge
  logic [1:0]      dcnt_r;     // number of entries removed by a merge
  logic            nxt_m_r;
  logic            prv_m_r;
  func_t           func_r;
  logic [NW-1:0]   need_r;
  logic [ADW-1:0]  addr_r;
  logic [3:0]      tag_r;
  logic [SZW-1:0]  acc_r;      // leftover size of a split
  logic [ADW-1:0]  res_addr_r;
  logic            status_r;
  logic            match_r;
  logic            out_valid_r;

  // Shared add/subtract unit.
  logic [AW-1:0]   alu_a, alu_b, alu_sum;
  logic [ADW-1:0]  usable;
  logic            srch_hit;
  assign alu_sum = alu_a + alu_b;
  assign usable  = ADW'(rd_q.start + SZW'(HEADER_BYTES));
  assign srch_hit = (func_r == FUNC_ALLOC) ? (!rd_q.used && !alu_sum[AW-1])
                                           : (rd_q.used && usable == addr_r);

  // Decode of the offered transaction.
  func_t           in_func;
  logic            null_free;
  logic            trivial;
  assign in_func   = func_t'(in_tdata[1:0]);
  assign null_free = (in_func == FUNC_FREE) && (in_tdata[34:19] == '0);
  assign trivial   = (in_func == FUNC_NONE) || null_free ||
                     ((in_func == FUNC_ALLOC) && (in_tdata[18:2] == '0));

  logic            busy;
  assign busy       = (state_r != S_IDLE);
  assign in_tready  = !busy && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, match_r, status_r, res_addr_r};

  // Segment table memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Memory ports and operand selection of the shared unit.
  always_comb begin
    alu_a   = AW'(rd_q.size);
    alu_b   = ~AW'(need_r) + AW'(1);
    rd_addr = idx_r[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[IW-1:0];
    wr_data = rd_q;
    if (!rst_n) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = {SZW'(0), SZW'(HEAP_BYTES), 1'b0, 4'd0};
    end else begin
      unique case (state_r)
        S_UP_WR: begin
          wr_en   = 1'b1;
          wr_addr = IW'(idx_r + CW'(1));
        end
        S_SPLIT_WR: begin
          wr_en   = 1'b1;
          alu_a   = AW'(cur_r.start);
          alu_b   = AW'(need_r);
          wr_addr = IW'(hit_r + CW'(1));
          wr_data = {SZW'(alu_sum), acc_r, 1'b0, 4'd0};
        end
        S_WR_HIT: begin
          wr_en   = 1'b1;
          wr_addr = IW'(hit_r);
          wr_data = cur_r;
        end
        S_NXT, S_PRV: begin
          alu_a = AW'(cur_r.size);
          alu_b = AW'(rd_q.size);
        end
        S_DN_RD: begin
          rd_addr = IW'(idx_r + CW'(dcnt_r));
        end
        S_DN_WR: begin
          wr_en = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(1);
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            func_r     <= in_func;
            need_r     <= ((NW'(in_tdata[18:2]) + NW'(BLOCK_BYTES - 1)) >> BSH) << BSH;
            addr_r     <= in_tdata[34:19];
            tag_r      <= in_tdata[38:35];
            res_addr_r <= '0;
            status_r   <= !null_free;
            match_r    <= 1'b0;
            idx_r      <= '0;
            nxt_m_r    <= 1'b0;
            prv_m_r    <= 1'b0;
            dcnt_r     <= '0;
            state_r    <= trivial ? S_DONE : S_RD;
          end
        end
        S_RD: state_r <= S_CHK;
        // Search one entry per pass.
        S_CHK: begin
          if (srch_hit) begin
            hit_r    <= idx_r;
            status_r <= 1'b0;
            if (func_r == FUNC_ALLOC) begin
              res_addr_r <= usable;
              cur_r      <= {rd_q.start, rd_q.size, 1'b1, tag_r};
              acc_r      <= SZW'(alu_sum);
              if (alu_sum > AW'(HEADER_BYTES) && count_r < CW'(MAX_SEGMENTS)) begin
                if (idx_r + CW'(1) == count_r) begin
                  state_r <= S_SPLIT_WR;
                end else begin
                  idx_r   <= count_r - CW'(1);
                  state_r <= S_UP_RD;
                end
              end else begin
                state_r <= S_WR_HIT;
              end
            end else if (func_r == FUNC_CHECK) begin
              match_r <= (rd_q.tag == tag_r);
              state_r <= S_DONE;
            end else begin
              cur_r <= {rd_q.start, rd_q.size, 1'b0, 4'd0};
              if (idx_r + CW'(1) < count_r) begin
                idx_r   <= idx_r + CW'(1);
                state_r <= S_NXT_RD;
              end else if (idx_r != '0) begin
                idx_r   <= idx_r - CW'(1);
                state_r <= S_PRV_RD;
              end else begin
                state_r <= S_MERGE;
              end
            end
          end else if (idx_r + CW'(1) >= count_r) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_RD;
          end
        end
        // Move the entries above the hit up by one, from the top down.
        S_UP_RD: state_r <= S_UP_WR;
        S_UP_WR: begin
          if (idx_r == hit_r + CW'(1)) begin
            state_r <= S_SPLIT_WR;
          end else begin
            idx_r   <= idx_r - CW'(1);
            state_r <= S_UP_RD;
          end
        end
        // The leftover becomes a free entry just above the granted one.
        S_SPLIT_WR: begin
          count_r    <= count_r + CW'(1);
          cur_r.size <= SZW'(need_r);
          state_r    <= S_WR_HIT;
        end
        S_WR_HIT: begin
          if (dcnt_r == '0) begin
            state_r <= S_DONE;
          end else if (drop_r + CW'(dcnt_r) >= count_r) begin
            count_r <= count_r - CW'(dcnt_r);
            state_r <= S_DONE;
          end else begin
            idx_r   <= drop_r;
            state_r <= S_DN_RD;
          end
        end
        // Free: look at the next and the previous neighbour.
        S_NXT_RD: state_r <= S_NXT;
        S_NXT: begin
          if (!rd_q.used) begin
            cur_r.size <= SZW'(alu_sum);
            nxt_m_r    <= 1'b1;
          end
          if (hit_r != '0) begin
            idx_r   <= hit_r - CW'(1);
            state_r <= S_PRV_RD;
          end else begin
            state_r <= S_MERGE;
          end
        end
        S_PRV_RD: state_r <= S_PRV;
        S_PRV: begin
          if (!rd_q.used) begin
            cur_r.start <= rd_q.start;
            cur_r.size  <= SZW'(alu_sum);
            prv_m_r     <= 1'b1;
          end
          state_r <= S_MERGE;
        end
        // Choose the entry that holds the merged segment and the ones removed.
        S_MERGE: begin
          if (prv_m_r) begin
            hit_r  <= hit_r - CW'(1);
            drop_r <= hit_r;
          end else begin
            drop_r <= hit_r + CW'(1);
          end
          dcnt_r  <= {1'b0, prv_m_r} + {1'b0, nxt_m_r};
          state_r <= S_WR_HIT;
        end
        // Move the entries above the removed ones down.
        S_DN_RD: state_r <= S_DN_WR;
        S_DN_WR: begin
          if (idx_r + CW'(1) + CW'(dcnt_r) >= count_r) begin
            count_r <= count_r - CW'(dcnt_r);
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_DN_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `FFHA_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r >= CW'(1) && count_r <= CW'(MAX_SEGMENTS))
  `FFHA_ASSERT_IMP(a_no_take_busy, clk, rst_n, busy, !in_tready)
  `FFHA_ASSERT_NXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, busy)
  `FFHA_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the first-fit heap allocator unit.
`timescale 1ns / 1ps
module tb_top;
  import ffha_pkg::*;

  localparam int unsigned HEAP   = HEAP_BYTES_DEF;
  localparam int unsigned BLK    = BLOCK_BYTES_DEF;
  localparam int unsigned HDR    = HEADER_BYTES_DEF;
  localparam int unsigned MAXSEG = MAX_SEGMENTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  first_fit_heap_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct packed {
    logic [15:0] addr;
    logic        status;
    logic        match;
  } answer_t;

  // Shadow copy of the segment table.
  seg_t        heap_segs [MAXSEG+1];
  int unsigned heap_count;
  answer_t     answers_due [$];
  // Live allocations, kept so that frees and checks mostly hit real blocks.
  logic [15:0] live_addrs [$];
  logic [3:0]  live_tags [$];

  int errors;
  int n_out;
  int n_allocs;
  int n_nulls;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;
  bit stall_test;

  // High and low half periods.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_heap_allocator_unit verification failed");
      $display("timeout after %0d cycles", cycles);
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_out);
  endtask

  function automatic logic [15:0] usable_addr(input int unsigned idx);
    return 16'((heap_segs[idx].start + HDR) & 17'hFFFF);
  endfunction

  function automatic void drop_seg(input int unsigned idx);
    for (int unsigned j = idx; j + 1 < heap_count; j++) heap_segs[j] = heap_segs[j+1];
    heap_count--;
  endfunction

  function automatic void reset_heap();
    heap_segs[0] = '0;
    heap_segs[0].size = 17'(HEAP);
    heap_count = 1;
  endfunction

  // Applies one transaction to the shadow heap and yields its answer.
  function automatic answer_t apply_request(input func_t fn, input logic [16:0] req,
                                            input logic [15:0] addr, input logic [3:0] tag);
    answer_t     a;
    int unsigned need;
    int unsigned left;
    int          hit;
    a = '{addr: 16'd0, status: 1'b1, match: 1'b0};
    hit = -1;
    if (fn != FUNC_ALLOC) begin
      for (int unsigned i = 0; i < heap_count; i++)
        if (hit < 0 && heap_segs[i].used && usable_addr(i) == addr) hit = i;
    end
    case (fn)
      FUNC_ALLOC: begin
        if (req != 0) begin
          need = ((int'(req) + BLK - 1) / BLK) * BLK;
          for (int unsigned i = 0; i < heap_count; i++) begin
            if (!heap_segs[i].used && heap_segs[i].size >= need) begin
              left = heap_segs[i].size - need;
              // Split off the leftover unless it is tiny or the table is full.
              if (left > HDR && heap_count < MAXSEG) begin
                for (int unsigned j = heap_count; j > i + 1; j--) heap_segs[j] = heap_segs[j-1];
                heap_segs[i+1].start = heap_segs[i].start + 17'(need);
                heap_segs[i+1].size  = 17'(left);
                heap_segs[i+1].used  = 1'b0;
                heap_segs[i+1].tag   = 4'd0;
                heap_count++;
                heap_segs[i].size = 17'(need);
              end
              heap_segs[i].used = 1'b1;
              heap_segs[i].tag  = tag;
              a.addr   = usable_addr(i);
              a.status = 1'b0;
              break;
            end
          end
        end
      end
      FUNC_FREE: begin
        if (addr == 0) begin
          a.status = 1'b0;
        end else if (hit >= 0) begin
          heap_segs[hit].used = 1'b0;
          heap_segs[hit].tag  = 4'd0;
          // Coalesce with the free neighbours on both sides.
          if (hit + 1 < heap_count && !heap_segs[hit+1].used) begin
            heap_segs[hit].size += heap_segs[hit+1].size;
            drop_seg(hit + 1);
          end
          if (hit > 0 && !heap_segs[hit-1].used) begin
            heap_segs[hit-1].size += heap_segs[hit].size;
            drop_seg(hit);
          end
          a.status = 1'b0;
        end
      end
      FUNC_CHECK: begin
        if (hit >= 0) begin
          a.status = 1'b0;
          a.match  = (heap_segs[hit].tag == tag);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Offers one transaction, then predicts it once accepted.
  task automatic send_request(input func_t fn, input logic [16:0] req,
                              input logic [15:0] addr, input logic [3:0] tag);
    answer_t a;
    bit      idle;
    idle = (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct);
    if (idle) in_tvalid <= 1'b0;
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(99, 0) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, tag, addr, req, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    a = apply_request(fn, req, addr, tag);
    answers_due.push_back(a);
    if (fn == FUNC_ALLOC && a.status == 1'b0) begin
      live_addrs.push_back(a.addr);
      live_tags.push_back(tag);
      n_allocs++;
    end
    if (fn == FUNC_ALLOC && a.status) n_nulls++;
    if (fn == FUNC_FREE) begin
      for (int k = 0; k < live_addrs.size(); k++)
        if (live_addrs[k] == addr) begin
          live_addrs.delete(k);
          live_tags.delete(k);
          break;
        end
    end
  endtask

  // Result side: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_test && hold_off < 400) begin
      hold_off   <= hold_off + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Compare every result with the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        want = answers_due.pop_front();
        if (out_tdata[15:0] != want.addr) report_mismatch("result_address", out_tdata[15:0], want.addr);
        if (out_tdata[16] != want.status) report_mismatch("status", out_tdata[16], want.status);
        if (out_tdata[17] != want.match) report_mismatch("purpose_match", out_tdata[17], want.match);
        if (out_tdata[23:18] != 0) report_mismatch("padding", out_tdata[23:18], 0);
      end
    end
  end

  // Directed stimulus: func, request, address, purpose, known answer if any.
  typedef struct {
    func_t       fn;
    logic [16:0] req;
    logic [15:0] addr;
    logic [3:0]  tag;
    bit          known;
    answer_t     ans;
  } directed_row_t;

  directed_row_t directed_rows [] = '{
    '{FUNC_FREE,  17'd0,     16'd0,      4'd0,  1, '{16'd0,  1'b0, 1'b0}},
    '{FUNC_CHECK, 17'd0,     16'd32,     4'd0,  1, '{16'd0,  1'b1, 1'b0}},
    '{FUNC_ALLOC, 17'd0,     16'hFFFF,   4'hF,  1, '{16'd0,  1'b1, 1'b0}},
    '{FUNC_NONE,  17'h1FFFF, 16'hFFFF,   4'hF,  1, '{16'd0,  1'b1, 1'b0}},
    '{FUNC_ALLOC, 17'h1FFFF, 16'd0,      4'd0,  1, '{16'd0,  1'b1, 1'b0}},
    '{FUNC_ALLOC, 17'd1,     16'd0,      4'd5,  1, '{16'd32, 1'b0, 1'b0}},
    '{FUNC_CHECK, 17'd0,     16'd32,     4'd5,  1, '{16'd0,  1'b0, 1'b1}},
    '{FUNC_CHECK, 17'd0,     16'd32,     4'd6,  1, '{16'd0,  1'b0, 1'b0}},
    '{FUNC_ALLOC, 17'd64,    16'd0,      4'hA,  0, '{16'd0,  1'b0, 1'b0}},
    '{FUNC_ALLOC, 17'd65,    16'd0,      4'h3,  0, '{16'd0,  1'b0, 1'b0}},
    '{FUNC_FREE,  17'd0,     16'd96,     4'd0,  0, '{16'd0,  1'b0, 1'b0}},
    '{FUNC_FREE,  17'd0,     16'd96,     4'd0,  1, '{16'd0,  1'b1, 1'b0}},
    '{FUNC_FREE,  17'd0,     16'd33,     4'd0,  1, '{16'd0,  1'b1, 1'b0}},
    '{FUNC_ALLOC, 17'd65536, 16'd0,      4'd1,  1, '{16'd0,  1'b1, 1'b0}},
    '{FUNC_FREE,  17'd0,     16'd32,     4'd0,  0, '{16'd0,  1'b0, 1'b0}},
    '{FUNC_FREE,  17'd0,     16'd160,    4'd0,  0, '{16'd0,  1'b0, 1'b0}},
    // Whole heap in one piece.
    '{FUNC_ALLOC, 17'd65536, 16'd0,      4'h9,  1, '{16'd32, 1'b0, 1'b0}},
    '{FUNC_ALLOC, 17'd1,     16'd0,      4'd0,  1, '{16'd0,  1'b1, 1'b0}},
    '{FUNC_FREE,  17'd0,     16'd32,     4'd0,  1, '{16'd0,  1'b0, 1'b0}},
    // Leaves a one-block leftover, which is split off.
    '{FUNC_ALLOC, 17'd65472, 16'd0,      4'h2,  1, '{16'd32, 1'b0, 1'b0}},
    '{FUNC_CHECK, 17'd0,     16'd32,     4'h2,  1, '{16'd0,  1'b0, 1'b1}},
    '{FUNC_FREE,  17'd0,     16'd32,     4'd0,  1, '{16'd0,  1'b0, 1'b0}}
  };

  task automatic run_random(input int count);
    int unsigned pick;
    logic [16:0] req;
    logic [15:0] addr;
    logic [3:0]  tag;
    int          k;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      req  = 17'($urandom_range(2000, 1));
      addr = 16'($urandom);
      tag  = 4'($urandom);
      if ($urandom_range(99, 0) < 3) req = 17'($urandom);
      if ($urandom_range(99, 0) < 2) req = 17'($urandom_range(65536, 40000));
      if (live_addrs.size() > 0) begin
        k = $urandom_range(live_addrs.size() - 1, 0);
        if ($urandom_range(99, 0) < 85) addr = live_addrs[k];
        if ($urandom_range(99, 0) < 60) tag = (pick & 1) ? live_tags[k] : tag;
      end
      // Allocation bias grows while the heap is sparse, frees when full.
      if (pick < (live_addrs.size() > 50 ? 25 : 50))
        send_request(FUNC_ALLOC, req, addr, tag);
      else if (pick < 80)
        send_request(FUNC_FREE, req, addr, tag);
      else if (pick < 97)
        send_request(FUNC_CHECK, req, addr, tag);
      else
        send_request(FUNC_NONE, req, addr, tag);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (answers_due.size() > 0) @(posedge clk);
    repeat (3 * MAXSEG + 10) @(posedge clk);
  endtask

  initial begin
    answer_t a;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    errors         = 0;
    n_out          = 0;
    n_allocs       = 0;
    n_nulls        = 0;
    cycles         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 0;
    stall_test     = 1'b0;
    reset_heap();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; known answers are checked against the predictor too.
    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].fn, directed_rows[r].req,
                   directed_rows[r].addr, directed_rows[r].tag);
      if (directed_rows[r].known) begin
        a = answers_due[answers_due.size()-1];
        if (a != directed_rows[r].ans) report_mismatch("directed table", a, directed_rows[r].ans);
        answers_due[answers_due.size()-1] = directed_rows[r].ans;
      end
    end
    live_addrs.delete();
    live_tags.delete();
    drain();

    // Long receiver hold-off while the sender keeps offering.
    stall_test = 1'b1;
    run_random(30);
    drain();

    run_random(500);
    send_idle_pct = 88;
    run_random(450);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    run_random(450);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    run_random(500);
    drain();

    $display("%0d results checked; %0d grants and %0d null allocations seen",
             n_out, n_allocs, n_nulls);
    if (errors == 0) begin
      $display("first_fit_heap_allocator_unit verification clean");
    end else begin
      $display("first_fit_heap_allocator_unit verification failed");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/ffha_pkg.sv
rtl/first_fit_heap_allocator_unit.sv
bench/tb_top.sv
